### rtl/tmp_pkg.sv
package tmp_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_DB_MUL,
    ST_DB_DIV,
    ST_DE_MUL,
    ST_DE_DIV,
    ST_VM_MUL,
    ST_VM_DIV,
    ST_TOTAL,
    ST_TA_MUL,
    ST_SQRT,
    ST_RT_DIV,
    ST_FT_DIV,
    ST_CT_DIV,
    ST_VP_MUL,
    ST_RD_DIV,
    ST_FINAL,
    ST_EVAL,
    ST_AT_MUL,
    ST_Q_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_RISE   = 2'd0,
    PH_CRUISE = 2'd1,
    PH_FALL   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  localparam logic [2:0] CFG_START_POS = 3'd0;
  localparam logic [2:0] CFG_START_VEL = 3'd1;
  localparam logic [2:0] CFG_END_POS   = 3'd2;
  localparam logic [2:0] CFG_END_VEL   = 3'd3;
  localparam logic [2:0] CFG_VEL_LIM   = 3'd4;
  localparam logic [2:0] CFG_ACC_LIM   = 3'd5;

  localparam logic [63:0] MAG_LIM = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] CT_SAT = 64'sh0000_0100_0000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] x);
    if (x == 32'sh8000_0000) return 32'sh7FFF_FFFF;
    return -x;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    logic signed [31:0] n;
    n = -x;
    return x[31] ? n : x;
  endfunction

  function automatic logic [31:0] clamp_time(input logic signed [63:0] t);
    if (t < 0) return 32'd0;
    if (t > 64'sh0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
    return t[31:0];
  endfunction

endpackage

### rtl/tmp_mul.sv
module tmp_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [1:0]   k_q;
  logic         busy_q, done_q;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] addend;

  assign ah = k_q[1] ? a_q[63:32] : a_q[31:0];
  assign bh = k_q[0] ? b_q[63:32] : b_q[31:0];
  assign pp = ah * bh;
  assign sh = {1'b0, k_q[1]} + {1'b0, k_q[0]};

  always_comb begin
    case (sh)
      2'd0:    addend = {64'd0, pp};
      2'd1:    addend = {32'd0, pp, 32'd0};
      default: addend = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= 2'd0;
      end else if (busy_q) begin
        k_q <= k_q + 2'd1;
        if (k_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/tmp_div.sv
module tmp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q, den_q;
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shifted, trial;
  logic        ge;
  logic signed [63:0] num_n;

  assign num_n   = -num_i;
  assign shifted = {rem_q, quo_q[63]};
  assign trial   = shifted - {1'b0, den_q};
  assign ge      = !trial[32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[63];
      quo_q <= num_i[63] ? num_n : num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[31:0] : shifted[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule

### rtl/tmp_sqrt.sv
module tmp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, r_q, bit_q;
  logic        busy_q, done_q;
  logic [63:0] sum;

  assign sum = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= sum) begin
        v_q <= v_q - sum;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

### rtl/trapezoid_motion_profile.sv
// Channel  Direction  Payload (low bit first)                      Transfer when
// s_axis   in         tdata: sample_time[31:0]                      tvalid & tready
// m_axis   out        tdata: out_position, out_velocity, travelled  tvalid & tready
//                     tuser: phase[1:0], status[2]
// cfg      in         cfg_index_i, cfg_data_i                       cfg_valid_i & cfg_ready_o
//
// With a current plan a rise or fall sample passes through evaluate, two passes of the shared
// 64x64 multiplier and output load; a cruise sample uses one multiply, a finished one none.
// The first sample after reset or a register write plans first: up to seven divides,
// five multiplies and a square root (with invalid limits these plan steps are skipped).
// Reset clears the registers to zero and forces a new plan. A full output register
// holds a result until taken; the next sample is taken and stalls at output load.
module trapezoid_motion_profile
  import tmp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // sample_time
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // out_position, out_velocity, travelled
  output logic [2:0]   m_axis_tuser,   // phase[1:0], status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic signed [63:0] CT_LIM = 64'sh7FFF_FFFF_FFFF_FFFF >>> FRAC_BITS;

  logic signed [31:0] sp_q, sv_q, ep_q, ev_q;
  logic [30:0]        vm_q, al_q;

  state_e state_q, state_d;
  logic   go_q, go_d;
  logic   plan_ready_q, plan_ready_d;
  logic   m_valid_q, m_valid_d;
  logic   cfg_wr;

  logic               tneg_q;
  logic signed [31:0] p0_q, v0_q, pf_q, vf_q;
  logic [31:0]        vp_q;
  logic [63:0]        sq_q, tmp_q;
  logic signed [63:0] tot_q, cruise_q, rt_q, ft_q, ct_q, rd_q;
  logic [31:0]        t0_q, t1_q, t2_q;
  logic signed [31:0] d0_q, d1_q;
  logic [31:0]        t_q, tm_q;
  phase_e             ph_q;
  logic signed [63:0] at_q, mq_q;

  logic signed [31:0] pos_q, vel_q, trav_q;
  logic [1:0]         phase_q;
  logic               status_q;

  logic               mul_start, div_start, sqrt_start;
  logic               mul_done, div_done, sqrt_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       prod;
  logic signed [63:0] div_num;
  logic [31:0]        div_den;
  logic signed [63:0] quo;
  logic [31:0]        root;

  logic               invalid, tneg_c, ct_skip, ct_sat;
  logic signed [31:0] vm_s, p0_c, v0_r, v0_c, pf_c, vf_c;
  logic [31:0]        a2, a32;
  logic signed [63:0] vp64, v0_64, vf64, p0_64;
  logic signed [63:0] at_half, x, xn, xmag_s;
  logic [63:0]        m_raw, m_cap;
  logic signed [63:0] tot_sum, rc_sum, rcf_sum;
  logic signed [63:0] pos_c, vel_c, pos_n, vel_n;
  phase_e             ph_c;
  logic               out_load;

  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign cfg_wr        = cfg_valid_i && cfg_ready_o && (cfg_index_i <= CFG_ACC_LIM);
  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      sv_q <= '0;
      ep_q <= '0;
      ev_q <= '0;
      vm_q <= '0;
      al_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_START_POS: sp_q <= cfg_data_i;
        CFG_START_VEL: sv_q <= cfg_data_i;
        CFG_END_POS:   ep_q <= cfg_data_i;
        CFG_END_VEL:   ev_q <= cfg_data_i;
        CFG_VEL_LIM:   vm_q <= cfg_data_i[30:0];
        CFG_ACC_LIM:   al_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign invalid = (vm_q == '0) || (al_q == '0);
  assign tneg_c  = ep_q < sp_q;
  assign vm_s    = signed'({1'b0, vm_q});
  assign p0_c    = tneg_c ? neg_sat32(sp_q) : sp_q;
  assign v0_r    = tneg_c ? neg_sat32(sv_q) : sv_q;
  assign pf_c    = tneg_c ? neg_sat32(ep_q) : ep_q;
  assign vf_c    = tneg_c ? neg_sat32(ev_q) : ev_q;
  assign v0_c    = (v0_r > vm_s) ? vm_s : ((v0_r < -vm_s) ? -vm_s : v0_r);

  assign a2    = {al_q, 1'b0};
  assign a32   = {1'b0, al_q};
  assign vp64  = signed'({32'd0, vp_q});
  assign v0_64 = 64'(v0_q);
  assign vf64  = 64'(vf_q);
  assign p0_64 = 64'(p0_q);

  assign at_half = at_q >>> 1;
  always_comb begin
    case (ph_q)
      PH_RISE: x = v0_64 + at_half;
      PH_FALL: x = vp64 - at_half;
      default: x = vp64;
    endcase
  end
  assign xn     = -x;
  assign xmag_s = x[63] ? xn : x;
  assign m_raw  = prod[63:0] >> FRAC_BITS;
  assign m_cap  = ((|prod[127:64]) || (m_raw > MAG_LIM)) ? MAG_LIM : m_raw;

  assign tot_sum = tot_q + quo + (64'(pf_q) - p0_64);
  assign rc_sum  = rt_q + ct_q;
  assign rcf_sum = rc_sum + ft_q;
  assign ct_skip = (cruise_q == 0) || (vp_q == '0);
  assign ct_sat  = cruise_q > CT_LIM;

  always_comb begin
    if (t_q < t0_q)      ph_c = PH_RISE;
    else if (t_q < t1_q) ph_c = PH_CRUISE;
    else if (t_q < t2_q) ph_c = PH_FALL;
    else                 ph_c = PH_DONE;
  end

  always_comb begin
    case (ph_q)
      PH_RISE: begin
        pos_c = p0_64 + mq_q;
        vel_c = v0_64 + at_q;
      end
      PH_CRUISE: begin
        pos_c = p0_64 + 64'(d0_q) + mq_q;
        vel_c = vp64;
      end
      PH_FALL: begin
        pos_c = p0_64 + 64'(d1_q) + mq_q;
        vel_c = vp64 - at_q;
      end
      default: begin
        pos_c = 64'(pf_q);
        vel_c = vf64;
      end
    endcase
  end
  assign pos_n = tneg_q ? -pos_c : pos_c;
  assign vel_n = tneg_q ? -vel_c : vel_c;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DB_MUL: begin
        mul_a = {32'd0, abs32(v0_q)};
        mul_b = {32'd0, abs32(v0_q)};
      end
      ST_DE_MUL: begin
        mul_a = {32'd0, abs32(vf_q)};
        mul_b = {32'd0, abs32(vf_q)};
      end
      ST_VM_MUL: begin
        mul_a = {33'd0, vm_q};
        mul_b = {33'd0, vm_q};
      end
      ST_TA_MUL: begin
        mul_a = tot_q;
        mul_b = {33'd0, al_q};
      end
      ST_VP_MUL: begin
        mul_a = {32'd0, vp_q};
        mul_b = {32'd0, vp_q};
      end
      ST_AT_MUL: begin
        mul_a = {32'd0, tm_q};
        mul_b = {33'd0, al_q};
      end
      ST_Q_MUL: begin
        mul_a = xmag_s;
        mul_b = {32'd0, tm_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_num = '0;
    div_den = a32;
    unique case (state_q)
      ST_DB_DIV: begin
        div_num = sq_q;
        div_den = a2;
      end
      ST_DE_DIV: begin
        div_num = tmp_q;
        div_den = a2;
      end
      ST_VM_DIV: div_num = tmp_q;
      ST_RT_DIV: div_num = (vp64 - v0_64) <<< FRAC_BITS;
      ST_FT_DIV: div_num = (vp64 - vf64) <<< FRAC_BITS;
      ST_CT_DIV: begin
        div_num = cruise_q <<< FRAC_BITS;
        div_den = vp_q;
      end
      ST_RD_DIV: begin
        div_num = tmp_q - sq_q;
        div_den = a2;
      end
      default: ;
    endcase
  end

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    go_d         = go_q;
    plan_ready_d = plan_ready_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = (plan_ready_q && !cfg_wr) ? ST_EVAL : ST_PREP;
      end
      ST_PREP: begin
        if (invalid) begin
          plan_ready_d = 1'b1;
          state_d      = ST_EVAL;
        end else begin
          state_d = ST_DB_MUL;
        end
      end
      ST_DB_MUL, ST_DE_MUL, ST_VM_MUL, ST_TA_MUL, ST_VP_MUL, ST_AT_MUL, ST_Q_MUL: begin
        mul_start = !go_q;
        if (mul_done) begin
          go_d = 1'b0;
          unique case (state_q)
            ST_DB_MUL: state_d = ST_DB_DIV;
            ST_DE_MUL: state_d = ST_DE_DIV;
            ST_VM_MUL: state_d = ST_VM_DIV;
            ST_TA_MUL: state_d = ST_SQRT;
            ST_VP_MUL: state_d = ST_RD_DIV;
            ST_AT_MUL: state_d = ST_Q_MUL;
            default:   state_d = ST_OUT;
          endcase
        end else begin
          go_d = 1'b1;
        end
      end
      ST_DB_DIV, ST_DE_DIV, ST_VM_DIV, ST_RT_DIV, ST_FT_DIV, ST_RD_DIV: begin
        div_start = !go_q;
        if (div_done) begin
          go_d = 1'b0;
          unique case (state_q)
            ST_DB_DIV: state_d = ST_DE_MUL;
            ST_DE_DIV: state_d = ST_VM_MUL;
            ST_VM_DIV: state_d = ST_TOTAL;
            ST_RT_DIV: state_d = ST_FT_DIV;
            ST_FT_DIV: state_d = ST_CT_DIV;
            default:   state_d = ST_FINAL;
          endcase
        end else begin
          go_d = 1'b1;
        end
      end
      ST_TOTAL: state_d = (cruise_q < 0) ? ST_TA_MUL : ST_RT_DIV;
      ST_SQRT: begin
        sqrt_start = !go_q;
        if (sqrt_done) begin
          go_d    = 1'b0;
          state_d = ST_RT_DIV;
        end else begin
          go_d = 1'b1;
        end
      end
      ST_CT_DIV: begin
        if (ct_skip || ct_sat) begin
          state_d = ST_VP_MUL;
        end else begin
          div_start = !go_q;
          if (div_done) begin
            go_d    = 1'b0;
            state_d = ST_VP_MUL;
          end else begin
            go_d = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        plan_ready_d = 1'b1;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        case (ph_c)
          PH_RISE, PH_FALL: state_d = ST_AT_MUL;
          PH_CRUISE:        state_d = ST_Q_MUL;
          default:          state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_wr) plan_ready_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      go_q         <= 1'b0;
      plan_ready_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      go_q         <= go_d;
      plan_ready_q <= plan_ready_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: t_q <= s_axis_tdata;
      ST_PREP: begin
        if (invalid) begin
          tneg_q <= 1'b0;
          p0_q   <= '0;
          v0_q   <= '0;
          pf_q   <= '0;
          vf_q   <= '0;
          vp_q   <= '0;
          t0_q   <= '0;
          t1_q   <= '0;
          t2_q   <= '0;
          d0_q   <= '0;
          d1_q   <= '0;
        end else begin
          tneg_q <= tneg_c;
          p0_q   <= p0_c;
          v0_q   <= v0_c;
          pf_q   <= pf_c;
          vf_q   <= vf_c;
        end
      end
      ST_DB_MUL: if (mul_done) sq_q <= prod[63:0];
      ST_DE_MUL, ST_VM_MUL, ST_TA_MUL, ST_VP_MUL: if (mul_done) tmp_q <= prod[63:0];
      ST_DB_DIV: if (div_done) tot_q <= quo;
      ST_DE_DIV: if (div_done) tot_q <= tot_sum[63] ? 64'sd0 : tot_sum;
      ST_VM_DIV: if (div_done) cruise_q <= tot_q - quo;
      ST_TOTAL:  if (!cruise_q[63]) vp_q <= {1'b0, vm_q};
      ST_SQRT: begin
        if (sqrt_done) begin
          vp_q     <= (root > {1'b0, vm_q}) ? {1'b0, vm_q} : root;
          cruise_q <= '0;
        end
      end
      ST_RT_DIV: if (div_done) rt_q <= quo;
      ST_FT_DIV: if (div_done) ft_q <= quo;
      ST_CT_DIV: begin
        if (ct_skip)       ct_q <= '0;
        else if (ct_sat)   ct_q <= CT_SAT;
        else if (div_done) ct_q <= quo;
      end
      ST_RD_DIV: if (div_done) rd_q <= quo;
      ST_FINAL: begin
        t0_q <= clamp_time(rt_q);
        t1_q <= clamp_time(rc_sum);
        t2_q <= clamp_time(rcf_sum);
        d0_q <= sat32(rd_q);
        d1_q <= sat32(rd_q + cruise_q);
      end
      ST_EVAL: begin
        ph_q <= ph_c;
        at_q <= '0;
        case (ph_c)
          PH_CRUISE: tm_q <= t_q - t0_q;
          PH_FALL:   tm_q <= t_q - t1_q;
          default:   tm_q <= t_q;
        endcase
      end
      ST_AT_MUL: if (mul_done) at_q <= signed'(prod[63:0] >> FRAC_BITS);
      ST_Q_MUL:  if (mul_done) mq_q <= x[63] ? -signed'(m_cap) : signed'(m_cap);
      ST_OUT: begin
        if (out_load) begin
          pos_q    <= sat32(pos_n);
          vel_q    <= sat32(vel_n);
          trav_q   <= sat32(pos_c - p0_64);
          phase_q  <= ph_q;
          status_q <= invalid;
        end
      end
      default: ;
    endcase
  end

  tmp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tmp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  tmp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (tmp_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {trav_q, vel_q, pos_q};
  assign m_axis_tuser  = {status_q, phase_q};

endmodule

### verif/testbench.sv
module testbench
  import tmp_pkg::*;
();

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] trav;
    logic [1:0]         ph;
    logic               st;
  } sample_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  trapezoid_motion_profile i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // register file and profile plan
  longint r_p0, r_v0, r_pf, r_vf, r_vm, r_a;
  bit plan_ok, neg_dir;
  logic [31:0] t_end [3];
  longint d_end [2];
  longint v_peak, ds_pos, ds_vel, de_pos, de_vel;

  logic [31:0] sample_q[$];
  sample_out_t profile_q[$];
  int errors = 0;
  bit hold_rx = 1'b0;
  longint cycles = 0;

  function automatic longint sat_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fx_mul(longint x, longint y);
    bit ng;
    logic [63:0] ux, uy, m;
    logic [127:0] pr;
    ng = (x < 0) != (y < 0);
    ux = x < 0 ? -x : x;
    uy = y < 0 ? -y : y;
    pr = 128'(ux) * 128'(uy);
    if (pr[127:64] != 0) m = 64'h2000_0000_0000_0000;
    else begin
      m = pr[63:0] >> 16;
      if (m > 64'h2000_0000_0000_0000) m = 64'h2000_0000_0000_0000;
    end
    return ng ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] t_clamp(longint t);
    if (t < 0) return 32'd0;
    if (t > 64'sh0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return t[31:0];
  endfunction

  task automatic build_plan();
    longint p0, v0, pf, vf, db, de, tot, cr, vp, rt, ct, ft, a2, rd;
    neg_dir = 0;
    t_end = '{0, 0, 0};
    d_end = '{0, 0};
    v_peak = 0; ds_pos = 0; ds_vel = 0; de_pos = 0; de_vel = 0;
    plan_ok = 1;
    if (r_vm == 0 || r_a == 0) return;
    neg_dir = r_pf < r_p0;
    p0 = r_p0; v0 = r_v0; pf = r_pf; vf = r_vf;
    if (neg_dir) begin
      p0 = sat_s32(-p0); v0 = sat_s32(-v0); pf = sat_s32(-pf); vf = sat_s32(-vf);
    end
    if (v0 > r_vm) v0 = r_vm;
    if (v0 < -r_vm) v0 = -r_vm;
    a2 = 2 * r_a;
    db = (v0 * v0) / a2;
    de = (vf * vf) / a2;
    tot = db + (pf - p0) + de;
    if (tot < 0) tot = 0;
    cr = tot - (r_vm * r_vm) / r_a;
    if (cr < 0) begin
      vp = root64(tot * r_a);
      if (vp > r_vm) vp = r_vm;
      cr = 0;
    end else begin
      vp = r_vm;
    end
    rt = ((vp - v0) * 65536) / r_a;
    ft = ((vp - vf) * 65536) / r_a;
    if (cr == 0 || vp == 0) ct = 0;
    else if (cr > 64'sh7FFF_FFFF_FFFF_FFFF / 65536) ct = 64'sd1 << 40;
    else ct = (cr * 65536) / vp;
    t_end[0] = t_clamp(rt);
    t_end[1] = t_clamp(rt + ct);
    t_end[2] = t_clamp(rt + ct + ft);
    rd = (vp * vp - v0 * v0) / a2;
    d_end[0] = sat_s32(rd);
    d_end[1] = sat_s32(rd + cr);
    v_peak = vp;
    ds_pos = p0; ds_vel = v0; de_pos = pf; de_vel = vf;
  endtask

  task automatic predict_sample(logic [31:0] t);
    sample_out_t e;
    longint at, pos, vel, tr;
    logic [31:0] dt;
    if (!plan_ok) build_plan();
    e.st = (r_vm == 0 || r_a == 0);
    if (t < t_end[0]) begin
      at = longint'((64'(t) * 64'(r_a)) >> 16);
      vel = ds_vel + at;
      pos = ds_pos + fx_mul(ds_vel + (at >>> 1), longint'(t));
      e.ph = PH_RISE;
    end else if (t < t_end[1]) begin
      vel = v_peak;
      pos = ds_pos + d_end[0] + fx_mul(v_peak, longint'(32'(t - t_end[0])));
      e.ph = PH_CRUISE;
    end else if (t < t_end[2]) begin
      dt = t - t_end[1];
      at = longint'((64'(dt) * 64'(r_a)) >> 16);
      vel = v_peak - at;
      pos = ds_pos + d_end[1] + fx_mul(v_peak - (at >>> 1), longint'(dt));
      e.ph = PH_FALL;
    end else begin
      pos = de_pos;
      vel = de_vel;
      e.ph = PH_DONE;
    end
    tr = sat_s32(pos - ds_pos);
    if (neg_dir) begin
      pos = -pos;
      vel = -vel;
    end
    e.pos = 32'(sat_s32(pos));
    e.vel = 32'(sat_s32(vel));
    e.trav = 32'(tr);
    profile_q.push_back(e);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_START_POS: r_p0 = longint'(signed'(val));
      CFG_START_VEL: r_v0 = longint'(signed'(val));
      CFG_END_POS:   r_pf = longint'(signed'(val));
      CFG_END_VEL:   r_vf = longint'(signed'(val));
      CFG_VEL_LIM:   r_vm = longint'(val[30:0]);
      CFG_ACC_LIM:   r_a = longint'(val[30:0]);
      default: ;
    endcase
    plan_ok = 0;
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !s_axis_tvalid && profile_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_q(int span);
    logic [31:0] v;
    v = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] rnd_wide();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return rnd_q(32'h0020_0000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_limit();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_sample(s_axis_tdata);
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample_q.pop_front();
        tx_gap = $urandom_range(0, 19) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 2);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  int rx_gap = 0;
  always @(posedge clk_i) begin
    sample_out_t got, e;
    if (m_axis_tvalid && m_axis_tready) begin
      got.pos = m_axis_tdata[31:0];
      got.vel = m_axis_tdata[63:32];
      got.trav = m_axis_tdata[95:64];
      got.ph = m_axis_tuser[1:0];
      got.st = m_axis_tuser[2];
      if (profile_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        e = profile_q.pop_front();
        if (got !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, got);
          errors++;
        end
      end
    end
    if (rx_gap > 0) rx_gap--;
    else if ($urandom_range(0, 9) == 0) rx_gap = $urandom_range(0, 9) == 0 ?
        $urandom_range(20, 80) : $urandom_range(1, 3);
    m_axis_tready <= !hold_rx && rx_gap == 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  logic [31:0] edge_t [8] = '{32'd0, 32'd1, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

  initial begin
    int n_sent;
    r_p0 = 0; r_v0 = 0; r_pf = 0; r_vf = 0; r_vm = 0; r_a = 0;
    plan_ok = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // invalid limits after reset
    for (int i = 0; i < 3; i++) sample_q.push_back(edge_t[i * 3]);
    drain();
    // nominal trapezoid, then a reverse move
    write_reg(CFG_START_POS, 32'h0000_0000);
    write_reg(CFG_START_VEL, 32'h0000_8000);
    write_reg(CFG_END_POS, 32'h0064_0000);
    write_reg(CFG_END_VEL, 32'h0000_0000);
    write_reg(CFG_VEL_LIM, 32'h000A_0000);
    write_reg(CFG_ACC_LIM, 32'h0004_0000);
    for (int i = 0; i < 8; i++) sample_q.push_back(edge_t[i]);
    for (int i = 0; i < 4; i++) sample_q.push_back(32'(i) * 32'h0008_0000);
    drain();
    write_reg(CFG_END_POS, 32'h8000_0000);
    write_reg(CFG_START_VEL, 32'h8000_0000);
    write_reg(CFG_VEL_LIM, 32'h7FFF_FFFF);
    write_reg(CFG_ACC_LIM, 32'h7FFF_FFFF);
    for (int i = 0; i < 8; i++) sample_q.push_back(edge_t[i]);
    drain();
    // long receiver hold while samples keep coming
    hold_rx = 1'b1;
    for (int i = 0; i < 12; i++) sample_q.push_back(rnd_sample());
    repeat (600) @(posedge clk_i);
    hold_rx = 1'b0;
    drain();
    n_sent = 0;
    while (n_sent < 1650) begin
      write_reg(CFG_START_POS, rnd_wide());
      write_reg(CFG_START_VEL, rnd_wide());
      write_reg(CFG_END_POS, rnd_wide());
      write_reg(CFG_END_VEL, rnd_wide());
      write_reg(CFG_VEL_LIM, rnd_limit());
      write_reg(CFG_ACC_LIM, rnd_limit());
      for (int i = 0; i < 40; i++) sample_q.push_back(rnd_sample());
      n_sent += 40;
      drain();
    end
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
